### rtl/gsbtb_pkg.sv
// Shared types and constants for the gshare predictor with branch target buffer.
package gsbtb_pkg;

  // Default table sizes; both entry counts must be powers of two.
  localparam int BTB_ENTRIES_DEF  = 1024;
  localparam int PHT_ENTRIES_DEF  = 256;
  localparam int HISTORY_BITS_DEF = 8;

  localparam int ADDR_W = 64;

  // Request operation codes.
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  // Two-bit saturating counter limits and the taken threshold.
  localparam logic [1:0] CTR_MIN   = 2'd0;
  localparam logic [1:0] CTR_MAX   = 2'd3;
  localparam logic [1:0] CTR_TAKEN = 2'd2;

  // Fall-through distance of one instruction.
  localparam logic [ADDR_W-1:0] INSN_BYTES = 64'd4;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] branch_target;
    logic              taken;
    logic              conditional;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic              predicted_taken;
  } rsp_t;

  // One branch target buffer entry as stored in memory.
  typedef struct packed {
    logic              valid;
    logic              is_cond;
    logic [ADDR_W-1:0] tag;
    logic [ADDR_W-1:0] dest;
  } btb_entry_t;

endpackage

### rtl/gshare_predictor_with_btb.sv
// Top level of the gshare branch predictor with a direct-mapped branch target buffer.
// Each request is handled in order: on acceptance the BTB and the pattern table are read
// from their synchronous memories; in the busy state the prediction is formed into the
// output register (predict) or the entry, counter and history are written back (update).
// Requests are taken only in the idle state, so one request is finished before the next
// is taken. A finished prediction waits in the output register without blocking
// acceptance of the next request, but a following prediction holds in the busy state
// until it drains. After reset the block clears max(BTB_ENTRIES, PHT_ENTRIES) entries
// (1024 with the defaults) and holds in_stall high until it is done. Both entry counts
// must be powers of two; the BTB is indexed by pc[log2(BTB_ENTRIES)+1:2] and the pattern
// table by pc[log2(PHT_ENTRIES)+1:2] XOR the global history.
module gshare_predictor_with_btb #(
  parameter int BTB_ENTRIES  = gsbtb_pkg::BTB_ENTRIES_DEF,
  parameter int PHT_ENTRIES  = gsbtb_pkg::PHT_ENTRIES_DEF,
  parameter int HISTORY_BITS = gsbtb_pkg::HISTORY_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  gsbtb_pkg::req_t in_req,
  output logic            out_valid,
  input  logic            out_stall,
  output gsbtb_pkg::rsp_t out_rsp
);
  import gsbtb_pkg::*;

  localparam int BTB_IDX   = $clog2(BTB_ENTRIES);
  localparam int PHT_IDX   = $clog2(PHT_ENTRIES);
  localparam int CLR_DEPTH = (BTB_ENTRIES > PHT_ENTRIES) ? BTB_ENTRIES : PHT_ENTRIES;
  localparam int CLR_IDX   = $clog2(CLR_DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  // Control and data registers.
  logic [1:0]              state_r, state_nxt;
  logic [CLR_IDX-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [HISTORY_BITS-1:0] hist_r, hist_nxt;
  logic                    out_valid_r, out_valid_nxt;
  rsp_t                    out_rsp_r, out_rsp_nxt;
  req_t                    item_r;
  logic [PHT_IDX-1:0]      pht_idx_r;

  // Memories and their registered read data.
  btb_entry_t              btb_mem [BTB_ENTRIES];
  logic [1:0]              pht_mem [PHT_ENTRIES];
  btb_entry_t              btb_rdata_r;
  logic [1:0]              pht_rdata_r;

  logic                    accept;
  logic [BTB_IDX-1:0]      btb_raddr;
  logic [PHT_IDX-1:0]      pht_raddr;
  logic                    btb_we, pht_we;
  logic [BTB_IDX-1:0]      btb_waddr;
  logic [PHT_IDX-1:0]      pht_waddr;
  btb_entry_t              btb_wdata;
  logic [1:0]              pht_wdata;
  logic [1:0]              ctr_moved;
  logic                    hit;
  logic                    out_free;
  logic                    is_update;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign is_update  = (state_r == ST_BUSY) && (item_r.operation == OP_UPDATE);

  // Read addresses come straight from the incoming request.
  assign btb_raddr = in_req.pc[BTB_IDX+1:2];
  assign pht_raddr = in_req.pc[PHT_IDX+1:2] ^ PHT_IDX'(hist_r);

  // Prediction from the registered table reads.
  assign hit = btb_rdata_r.valid && (btb_rdata_r.tag == item_r.pc) &&
               (!btb_rdata_r.is_cond || (pht_rdata_r >= CTR_TAKEN));

  // Saturating counter move toward the resolved outcome.
  always_comb begin
    ctr_moved = pht_rdata_r;
    if (item_r.taken) begin
      if (pht_rdata_r != CTR_MAX) ctr_moved = pht_rdata_r + 2'd1;
    end else begin
      if (pht_rdata_r != CTR_MIN) ctr_moved = pht_rdata_r - 2'd1;
    end
  end

  // Write ports: clearing pass or update write-back.
  always_comb begin
    btb_we    = 1'b0;
    pht_we    = 1'b0;
    btb_waddr = item_r.pc[BTB_IDX+1:2];
    pht_waddr = pht_idx_r;
    btb_wdata = '{valid: 1'b1, is_cond: item_r.conditional, tag: item_r.pc,
                  dest: item_r.branch_target};
    pht_wdata = ctr_moved;
    if (state_r == ST_CLEAR) begin
      btb_we    = 1'b1;
      pht_we    = 1'b1;
      btb_waddr = clr_cnt_r[BTB_IDX-1:0];
      pht_waddr = clr_cnt_r[PHT_IDX-1:0];
      btb_wdata = '0;
      pht_wdata = CTR_MIN;
    end else if (is_update) begin
      btb_we = 1'b1;
      pht_we = item_r.conditional;
    end
  end

  // Sequencer, history and output register next values.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    hist_nxt      = hist_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_IDX'(CLR_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_BUSY;
      end
      ST_BUSY: begin
        if (item_r.operation == OP_UPDATE) begin
          if (item_r.conditional) begin
            hist_nxt = {hist_r[HISTORY_BITS-2:0], item_r.taken};
          end
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_rsp_nxt.predicted_taken = hit;
          out_rsp_nxt.next_pc         = hit ? btb_rdata_r.dest : item_r.pc + INSN_BYTES;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hist_r      <= hist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
    if (accept) begin
      item_r    <= in_req;
      pht_idx_r <= pht_raddr;
    end
  end

  // Branch target buffer memory.
  always_ff @(posedge clk) begin
    if (btb_we) btb_mem[btb_waddr] <= btb_wdata;
    if (accept) btb_rdata_r <= btb_mem[btb_raddr];
  end

  // Pattern history table memory.
  always_ff @(posedge clk) begin
    if (pht_we) pht_mem[pht_waddr] <= pht_wdata;
    if (accept) pht_rdata_r <= pht_mem[pht_raddr];
  end

  // An accepted update never produces a result.
  a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.operation == OP_UPDATE) |=> ##1 !$rose(out_valid_r))
    else $error("update request produced a result");

  // The history only moves after a conditional update write-back.
  a_hist_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(hist_r)) |->
      $past(is_update && item_r.conditional))
    else $error("history changed without a conditional update");

  // No result is presented while the tables are being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result valid during clearing pass");

endmodule
